>>> rtl/podo_pkg.sv
// podo_pkg: shared types, constants and tables of the planar odometry integrator
// no dependencies; imported by podo_ctrl, podo_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package podo_pkg;

    localparam int POS_BITS_DEF     = 48;
    localparam int ANGLE_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 20;

    // counter and step index width, covers up to 32 cordic rotations
    localparam int IDX_W     = 5;
    localparam int DIV_STEPS = 3;

    localparam int CORD_W = 34;

    localparam longint CORDIC_INIT = 64'd652032874;
    localparam longint TURN_K      = 64'd183493156;
    localparam longint NS_HALF     = 64'd500000000;
    localparam int     SIDE_TO_MM  = 10;

    // divide by 1e9: drop the 2^9 factor, then multiply by ceil(2^67 / 5^9)
    // and keep bits from 67 up; exact for dividends below 2^55
    localparam int     DIV_PRE_SHIFT  = 9;
    localparam int     DIV_CHUNK      = 16;
    localparam int     DIV_POST_SHIFT = 35;
    localparam longint DIV_RECIP      = 64'd75557863725915;

    typedef struct packed {
        logic               func;
        logic signed [15:0] fwd_vel_mm_s;
        logic signed [15:0] side_vel_cm_s;
        logic signed [15:0] yaw_rate_mrad_s;
        logic [19:0]        elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [31:0]        heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CORD_LOAD_POS,
        OP_CORD_LOAD_QUAT,
        OP_CORD_STEP,
        OP_MUL1,
        OP_MUL2,
        OP_DIV,
        OP_ACC,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // arctangent of 2^-i as a binary angle, 2^32 = one turn
    function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051D;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2E;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000028;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000002;
            5'd29:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/podo_ctrl.sv
// podo_ctrl: sequencer for the odometry integrator, drives the datapath by command
// depends on podo_pkg
`timescale 1ns / 1ps
`default_nettype none

module podo_ctrl
    import podo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_func,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_CORD_POS  = 9'b000000010,
        S_MUL1      = 9'b000000100,
        S_MUL2      = 9'b000001000,
        S_DIV       = 9'b000010000,
        S_ACC       = 9'b000100000,
        S_QLOAD     = 9'b001000000,
        S_CORD_QUAT = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    localparam logic [IDX_W-1:0] CORD_LAST = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] DIV_FIRST = IDX_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;
    logic             slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.idx        = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    if (in_func)
                    begin
                        cmd.op     = OP_CORD_LOAD_POS;
                        state_next = S_CORD_POS;
                    end
                    else
                    begin
                        cmd.op = OP_LATCH;
                    end
                end
            end
            S_CORD_POS:
            begin
                cmd.op   = OP_CORD_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                cnt_next   = DIV_FIRST;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_QLOAD;
            end
            S_QLOAD:
            begin
                cmd.op     = OP_CORD_LOAD_QUAT;
                cnt_next   = '0;
                state_next = S_CORD_QUAT;
            end
            S_CORD_QUAT:
            begin
                cmd.op   = OP_CORD_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait until the previous result has been transferred
                if (slot_free)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_func |=> !in_ready)
        else $error("input still open after a tick transfer");

    a_out_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> slot_free)
        else $error("result written over an untransferred result");

    a_out_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |=> out_valid)
        else $error("result written but not offered");

    a_cordic_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CORD_STEP) |-> (cnt_reg <= CORD_LAST))
        else $error("cordic step index out of range");

endmodule

`default_nettype wire

>>> rtl/podo_dp.sv
// podo_dp: datapath of the odometry integrator: cordic, multipliers, divider lanes, pose
// depends on podo_pkg; sequenced by podo_ctrl through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module podo_dp
    import podo_pkg::*;
#(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_data,
    input  wire cmd_t      cmd,
    output out_item_t      out_data
);

    localparam int SW = POS_BITS + 3;
    localparam int SH = 60 - ANGLE_BITS;
    localparam int CW = CORD_W;
    localparam int PW = 56;
    localparam int AW = 42;
    localparam int NW = 63;

    localparam logic signed [SW-1:0] POS_MAX = (SW'(1) << (POS_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);

    // pose state
    logic signed [15:0]         fwd_vel_reg, side_vel_reg, yaw_rate_reg;
    logic signed [POS_BITS-1:0] x_accum_reg, y_accum_reg;
    logic [ANGLE_BITS-1:0]      heading_reg;

    // working registers
    logic [19:0]          us_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic                 flip_reg;
    logic signed [PW-1:0] prod_x_reg, prod_y_reg;
    logic [35:0]          yaw_m_reg;
    logic [63:0]          hp_reg;
    logic [NW-1:0]        rem_x_reg, rem_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [63:0]          q_x_reg, q_y_reg;
    logic                 sat_reg;
    out_item_t            out_reg;

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [15:0]   r;
        t = (v + CW'(16384)) >>> 15;
        if (t > CW'(32767))
            r = 16'sd32767;
        else if (t < -CW'(32768))
            r = -16'sd32768;
        else
            r = 16'(t);
        return r;
    endfunction

    // cordic
    logic [31:0]          h32, ang, turned, ang_f;
    logic                 flip;
    logic signed [CW-1:0] xs, ys, at, c_val, s_val;

    assign h32    = 32'(heading_reg) << (32 - ANGLE_BITS);
    assign ang    = (cmd.op == OP_CORD_LOAD_QUAT) ? (h32 >> 1) : h32;
    assign turned = ang + 32'h40000000;
    assign flip   = turned[31];
    assign ang_f  = ang ^ {flip, 31'd0};
    assign xs     = cx_reg >>> cmd.idx;
    assign ys     = cy_reg >>> cmd.idx;
    assign at     = signed'(CW'(atan_entry(cmd.idx)));
    assign c_val  = flip_reg ? -cx_reg : cx_reg;
    assign s_val  = flip_reg ? -cy_reg : cy_reg;

    // body to world rotation
    logic signed [19:0] side_mm;
    logic signed [49:0] p_fc, p_fs;
    logic signed [53:0] p_mc, p_ms;
    logic [15:0]        yaw_mag;

    assign side_mm = side_vel_reg * $signed(20'(SIDE_TO_MM));
    assign p_fc    = fwd_vel_reg * c_val;
    assign p_fs    = fwd_vel_reg * s_val;
    assign p_mc    = side_mm * c_val;
    assign p_ms    = side_mm * s_val;
    assign yaw_mag = yaw_rate_reg[15] ? (~yaw_rate_reg + 16'd1) : yaw_rate_reg;

    // round to q16, magnitude times elapsed time
    logic signed [PW-1:0] rnd_x, rnd_y;
    logic signed [AW-1:0] a16_x, a16_y;
    logic [AW-1:0]        mag_x, mag_y;
    logic [NW-1:0]        num_x, num_y;

    assign rnd_x = prod_x_reg + PW'(8192);
    assign rnd_y = prod_y_reg + PW'(8192);
    assign a16_x = AW'(rnd_x >>> 14);
    assign a16_y = AW'(rnd_y >>> 14);
    assign mag_x = a16_x[AW-1] ? AW'(-a16_x) : AW'(a16_x);
    assign mag_y = a16_y[AW-1] ? AW'(-a16_y) : AW'(a16_y);
    assign num_x = NW'(mag_x) * NW'(us_reg) + NW'(NS_HALF);
    assign num_y = NW'(mag_y) * NW'(us_reg) + NW'(NS_HALF);

    // division by one billion as a reciprocal multiply, 16 dividend bits per step,
    // low chunk first; the running sum drops the 16 bits it has finished with
    logic [63:0] pp_x, pp_y;
    logic [31:0] quo_x, quo_y;

    assign pp_x  = 64'(rem_x_reg[DIV_CHUNK-1:0]) * 64'(DIV_RECIP);
    assign pp_y  = 64'(rem_y_reg[DIV_CHUNK-1:0]) * 64'(DIV_RECIP);
    assign quo_x = 32'(q_x_reg >> DIV_POST_SHIFT);
    assign quo_y = 32'(q_y_reg >> DIV_POST_SHIFT);

    // saturating position update and heading step
    logic signed [33:0]         dx, dy;
    logic signed [SW-1:0]       sum_x, sum_y;
    logic signed [POS_BITS-1:0] x_new, y_new;
    logic                       sat_x, sat_y;
    logic [63:0]                hp_rnd;
    logic [ANGLE_BITS-1:0]      dh;

    assign dx     = neg_x_reg ? -signed'({2'b00, quo_x}) : signed'({2'b00, quo_x});
    assign dy     = neg_y_reg ? -signed'({2'b00, quo_y}) : signed'({2'b00, quo_y});
    assign sum_x  = SW'(x_accum_reg) + SW'(dx);
    assign sum_y  = SW'(y_accum_reg) + SW'(dy);
    assign sat_x  = (sum_x > POS_MAX) || (sum_x < POS_MIN);
    assign sat_y  = (sum_y > POS_MAX) || (sum_y < POS_MIN);
    assign x_new  = (sum_x > POS_MAX) ? POS_BITS'(POS_MAX) :
                    (sum_x < POS_MIN) ? POS_BITS'(POS_MIN) : POS_BITS'(sum_x);
    assign y_new  = (sum_y > POS_MAX) ? POS_BITS'(POS_MAX) :
                    (sum_y < POS_MIN) ? POS_BITS'(POS_MIN) : POS_BITS'(sum_y);
    assign hp_rnd = hp_reg + (64'd1 << (SH - 1));
    assign dh     = ANGLE_BITS'(hp_rnd >> SH);

    logic signed [63:0] x_ext, y_ext;
    assign x_ext = 64'(x_accum_reg);
    assign y_ext = 64'(y_accum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vel_reg  <= '0;
            side_vel_reg <= '0;
            yaw_rate_reg <= '0;
            x_accum_reg  <= '0;
            y_accum_reg  <= '0;
            heading_reg  <= '0;
        end
        else
        begin
            if (cmd.op == OP_LATCH)
            begin
                fwd_vel_reg  <= in_data.fwd_vel_mm_s;
                side_vel_reg <= in_data.side_vel_cm_s;
                yaw_rate_reg <= in_data.yaw_rate_mrad_s;
            end
            if (cmd.op == OP_ACC)
            begin
                x_accum_reg <= x_new;
                y_accum_reg <= y_new;
                if (yaw_rate_reg[15])
                    heading_reg <= heading_reg - dh;
                else
                    heading_reg <= heading_reg + dh;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CORD_LOAD_POS, OP_CORD_LOAD_QUAT:
            begin
                if (cmd.op == OP_CORD_LOAD_POS)
                    us_reg <= in_data.elapsed_us;
                cx_reg   <= CW'(CORDIC_INIT);
                cy_reg   <= '0;
                cz_reg   <= CW'($signed(ang_f));
                flip_reg <= flip;
            end
            OP_CORD_STEP:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
            OP_MUL1:
            begin
                prod_x_reg <= PW'(p_fc) - PW'(p_ms);
                prod_y_reg <= PW'(p_fs) + PW'(p_mc);
                yaw_m_reg  <= 36'(yaw_mag) * 36'(us_reg);
            end
            OP_MUL2:
            begin
                rem_x_reg <= num_x >> DIV_PRE_SHIFT;
                rem_y_reg <= num_y >> DIV_PRE_SHIFT;
                neg_x_reg <= a16_x[AW-1];
                neg_y_reg <= a16_y[AW-1];
                q_x_reg   <= '0;
                q_y_reg   <= '0;
                hp_reg    <= 64'(yaw_m_reg) * 64'(TURN_K);
            end
            OP_DIV:
            begin
                rem_x_reg <= rem_x_reg >> DIV_CHUNK;
                rem_y_reg <= rem_y_reg >> DIV_CHUNK;
                q_x_reg   <= (q_x_reg >> DIV_CHUNK) + pp_x;
                q_y_reg   <= (q_y_reg >> DIV_CHUNK) + pp_y;
            end
            OP_ACC:
            begin
                sat_reg <= sat_x || sat_y;
            end
            OP_OUT:
            begin
                out_reg.pos_x     <= x_ext[47:0];
                out_reg.pos_y     <= y_ext[47:0];
                out_reg.heading   <= h32;
                out_reg.quat_z    <= to_q15(s_val);
                out_reg.quat_w    <= to_q15(c_val);
                out_reg.saturated <= sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/planar_odometry_integrator_unit.sv
// planar_odometry_integrator_unit: top level of the 2-d dead-reckoning integrator
// depends on podo_pkg, podo_ctrl and podo_dp
//
// usage:
//   in channel (in_valid/in_ready/in_data): func=0 latches forward, lateral and yaw
//   velocities and produces no result; func=1 is a tick carrying elapsed_us that
//   rotates the body velocity by the heading, integrates position, advances the
//   heading and produces exactly one result on the out channel
//   (out_valid/out_ready/out_data): pose, heading and yaw quaternion z, w
//   a velocity transfer leaves the input ready; a tick runs the position cordic
//   pass, two multiplies, the 3-step reciprocal multiply that divides by 1e9, the
//   accumulate and the quaternion cordic pass, each pass one rotation per cycle;
//   its result is offered as in_ready rises, once the result register frees
//   the result register sits between the sides: a new item is taken while a
//   finished result still waits; if the receiver stalls longer than a whole tick,
//   the next result holds in the sequencer until the register frees
//   reset clears velocities, position, heading and out_valid
`timescale 1ns / 1ps
`default_nettype none

module planar_odometry_integrator_unit
    import podo_pkg::*;
#(
    parameter int POS_BITS     = POS_BITS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    cmd_t cmd;

    podo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (in_data.func),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    podo_dp #(
        .POS_BITS   (POS_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
